// ----- hw/rtl/grid_q_learning_step_macros.svh -----
// ----------------------------------------------------------------------------
// grid_q_learning_step_macros
// assertion macros used by the checker file of the q-learning block
// ----------------------------------------------------------------------------
`ifndef GRID_Q_LEARNING_STEP_MACROS_SVH
`define GRID_Q_LEARNING_STEP_MACROS_SVH

// same-cycle implication
`define QLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qls assertion failed");

// next-cycle implication
`define QLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qls assertion failed");

`endif

// ----- hw/rtl/qls_pkg.sv -----
// ----------------------------------------------------------------------------
// qls_pkg
// types, codes and constants of the grid q-learning step block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qls_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_Q_WIDTH  = 32;
    localparam int ACTION_COUNT = 4;

    // wide arithmetic width, multiplier operand width, fraction width
    localparam int EW = 68;
    localparam int MW = 64;
    localparam int FW = 16;

    localparam int FLOOR_INT = 9999;
    localparam logic signed [EW-1:0] Q_FLOOR = -(EW'(FLOOR_INT) <<< FW);
    localparam logic signed [EW-1:0] LIM62   = EW'(1) <<< 62;

    localparam logic signed [10:0] REWARD_STEP    = -11'sd1;
    localparam logic signed [10:0] REWARD_VISITED = -11'sd100;

    localparam logic [6:0]  DEF_ROWS_USED   = 7'd64;
    localparam logic [6:0]  DEF_COLS_USED   = 7'd64;
    localparam logic [9:0]  DEF_GOAL_REWARD = 10'd10;
    localparam logic [15:0] DEF_LEARN_RATE  = 16'd6554;
    localparam logic [15:0] DEF_DISCOUNT    = 16'd58982;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PLACE = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_ROWS_USED   = 3'd0,
        CFG_COLS_USED   = 3'd1,
        CFG_GOAL_ROW    = 3'd2,
        CFG_GOAL_COL    = 3'd3,
        CFG_GOAL_REWARD = 3'd4,
        CFG_LEARN_RATE  = 3'd5,
        CFG_DISCOUNT    = 3'd6
    } t_cfg_idx;

    localparam logic [2:0] CODE_OPEN    = 3'd0;
    localparam logic [2:0] CODE_WALL    = 3'd1;
    localparam logic [2:0] CODE_VISITED = 3'd3;
    localparam logic [2:0] CODE_AGENT   = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;
    localparam logic [2:0] ACT_NONE  = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_OPEN = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_CHOOSE,
        S_MAXQ,
        S_MUL_G,
        S_TD,
        S_MUL_A,
        S_WRITE_OLD,
        S_WRITE_NEW,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic signed [MW-1:0] a;
        logic [FW-1:0]        f;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [MW:0] res;
    } t_mul_rsp;

    function automatic logic signed [EW-1:0] clamp_ew(
        input logic signed [EW-1:0] v,
        input logic signed [EW-1:0] lo,
        input logic signed [EW-1:0] hi
    );
        logic signed [EW-1:0] r;
        r = v;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        return r;
    endfunction

    // remainder by three through base-four digit sum
    function automatic logic [1:0] mod3(input logic [7:0] p);
        logic [3:0] s;
        logic [1:0] r;
        s = 4'(p[1:0]) + 4'(p[3:2]) + 4'(p[5:4]) + 4'(p[7:6]);
        unique case (s)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
            default:                       r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/qls_ram.sv -----
// ----------------------------------------------------------------------------
// qls_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qls_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_addr,
    input  logic [W-1:0]         i_wdata,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/qls_mul.sv -----
// ----------------------------------------------------------------------------
// qls_mul
// signed by unsigned-fraction multiplier, one 16-bit digit per cycle,
// rounded to nearest with ties toward plus infinity
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qls_mul import qls_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int NCH   = MW / FW;
    localparam int CNT_W = $clog2(NCH);
    localparam int PW    = MW + FW + 1;

    logic signed [MW-1:0]   r_a;
    logic [FW-1:0]          r_f;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic signed [PW-1:0]   r_acc;

    logic [FW-1:0]          w_chunk;
    logic signed [FW:0]     w_digit;
    logic signed [2*FW+1:0] w_pp;
    logic signed [PW-1:0]   w_sum;
    logic signed [PW-1:0]   w_round;

    always_comb begin
        w_chunk = r_a[r_cnt*FW +: FW];
        w_digit = (r_cnt == CNT_W'(NCH-1)) ? {w_chunk[FW-1], w_chunk} : {1'b0, w_chunk};
        w_pp    = w_digit * $signed({1'b0, r_f});
        w_sum   = (r_acc <<< FW) + PW'(w_pp);
        w_round = r_acc + (PW'(1) <<< (FW-1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= $signed(i_req.a);
            r_f   <= i_req.f;
            r_cnt <= CNT_W'(NCH-1);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= w_sum;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = w_round[PW-1:FW];

endmodule

// ----- hw/rtl/grid_q_learning_step.sv -----
// ----------------------------------------------------------------------------
// grid_q_learning_step
// tabular q-learning agent on a grid maze with maze and q-table memories
// ----------------------------------------------------------------------------
// One item is handled at a time. A load or place item goes from the start
// state straight to the result; a greedy query scans the queried cell, and
// a learning step scans the agent's cell and, when a direction is open, the
// chosen neighbor: the maze memory has one port, so the four neighbor codes
// of a cell are read one per cycle, and the two fractional products each
// pass through a 16-bit digit multiplier. After reset the block clears all
// MAX_ROWS*MAX_COLS cells (4096 by default) of both memories, during which
// no item is taken; configuration writes are taken at any time. A finished
// result waits in an output register while the next item is taken.
`timescale 1ns / 1ps

module grid_q_learning_step import qls_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int Q_WIDTH  = DEF_Q_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic [2:0]         i_cell_code,
    input  logic               i_explore,
    input  logic [7:0]         i_random_pick,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_action,
    output logic signed [10:0] o_reward,
    output logic [5:0]         o_agent_row_out,
    output logic [5:0]         o_agent_col_out,
    output logic signed [31:0] o_q_new,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = ACTION_COUNT * Q_WIDTH;
    localparam logic signed [EW-1:0] QMAX = (EW'(1) <<< (Q_WIDTH-1)) - EW'(1);
    localparam logic signed [EW-1:0] QMIN = -QMAX - EW'(1);

    function automatic logic in_grid(
        input logic [6:0] r,
        input logic [6:0] c,
        input logic [6:0] rows,
        input logic [6:0] cols
    );
        return (r < rows) && (c < cols) && (int'(r) < MAX_ROWS) && (int'(c) < MAX_COLS);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
        return AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
    endfunction

    t_state r_state, n_state;

    logic [6:0]  r_rows_used, r_cols_used;
    logic [5:0]  r_goal_row, r_goal_col;
    logic [9:0]  r_goal_reward;
    logic [15:0] r_learn_rate, r_discount;

    t_cmd        r_cmd;
    logic [5:0]  r_row, r_col;
    logic [2:0]  r_code;
    logic        r_explore;
    logic [7:0]  r_pick;

    logic [6:0]  r_agent_row, r_agent_col;
    logic [6:0]  r_cr, r_cc;
    logic [6:0]  r_new_row, r_new_col;
    logic        r_phase;
    logic [2:0]  r_scan_cnt;
    logic [2:0]  r_nb_code [ACTION_COUNT];
    logic [RW-1:0] r_qrow, r_qrow_old;
    logic [1:0]  r_act;
    logic signed [10:0]   r_reward;
    logic signed [EW-1:0] r_q_old, r_target, r_qn;
    logic [2:0]  r_res_action;
    logic [1:0]  r_res_status;
    logic [AW-1:0] r_clr;

    logic               r_out_valid;
    logic [2:0]         r_o_action;
    logic signed [10:0] r_o_reward;
    logic [5:0]         r_o_agent_row, r_o_agent_col;
    logic signed [31:0] r_o_q_new;
    logic [1:0]         r_o_status;

    logic [6:0]    w_nb_row [ACTION_COUNT];
    logic [6:0]    w_nb_col [ACTION_COUNT];
    logic          w_nb_ok  [ACTION_COUNT];
    logic          w_open   [ACTION_COUNT];
    logic [AW-1:0] w_nb_addr [ACTION_COUNT];
    logic signed [EW-1:0] w_qv [ACTION_COUNT];

    logic [2:0] w_cnt, w_seen, w_k;
    logic       w_any, w_gfound, w_qfound;
    logic [1:0] w_first, w_gact, w_qact, w_eact, w_kmod, w_chosen;
    logic signed [EW-1:0] w_gm, w_qm, w_td;

    logic          w_accept, w_adv, w_in_rc, w_in_agent;
    logic          w_m_we, w_q_we;
    logic [AW-1:0] w_m_addr, w_q_addr;
    logic [2:0]    w_m_wdata, w_m_rdata;
    logic [RW-1:0] w_q_wdata, w_q_rdata;
    t_mul_req      w_mul_req;
    t_mul_rsp      w_mul_rsp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_adv       = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);
    assign w_in_rc     = in_grid({1'b0, r_row}, {1'b0, r_col}, r_rows_used, r_cols_used);
    assign w_in_agent  = in_grid(r_agent_row, r_agent_col, r_rows_used, r_cols_used);

    // neighbors of the center cell
    always_comb begin
        for (int d = 0; d < ACTION_COUNT; d++) begin
            w_nb_row[d] = r_cr;
            w_nb_col[d] = r_cc;
            w_nb_ok[d]  = 1'b1;
            unique case (2'(d))
                DIR_UP: begin
                    w_nb_row[d] = r_cr - 7'd1;
                    w_nb_ok[d]  = (r_cr != '0);
                end
                DIR_LEFT: begin
                    w_nb_col[d] = r_cc - 7'd1;
                    w_nb_ok[d]  = (r_cc != '0);
                end
                DIR_DOWN: begin
                    w_nb_row[d] = r_cr + 7'd1;
                end
                DIR_RIGHT: begin
                    w_nb_col[d] = r_cc + 7'd1;
                end
            endcase
            w_open[d] = w_nb_ok[d] && in_grid(w_nb_row[d], w_nb_col[d], r_rows_used, r_cols_used)
                        && (r_nb_code[d] != CODE_WALL);
            w_nb_addr[d] = cell_addr(w_nb_row[d], w_nb_col[d]);
            w_qv[d] = EW'($signed(r_qrow[d*Q_WIDTH +: Q_WIDTH]));
        end
    end

    // direction choice over the scanned cell
    always_comb begin
        w_cnt    = '0;
        w_first  = '0;
        w_any    = 1'b0;
        w_gm     = Q_FLOOR;
        w_gact   = '0;
        w_gfound = 1'b0;
        w_qm     = Q_FLOOR;
        w_qact   = '0;
        w_qfound = 1'b0;
        for (int d = 0; d < ACTION_COUNT; d++) begin
            if (w_open[d]) begin
                w_cnt = w_cnt + 3'd1;
                if (!w_any) begin
                    w_first = 2'(d);
                    w_any   = 1'b1;
                end
                if (w_qv[d] > w_gm) begin
                    w_gm     = w_qv[d];
                    w_gact   = 2'(d);
                    w_gfound = 1'b1;
                end
                if ((w_qv[d] > w_qm) && (w_qv[d] != '0)) begin
                    w_qm     = w_qv[d];
                    w_qact   = 2'(d);
                    w_qfound = 1'b1;
                end
            end
        end
        unique case (w_cnt)
            3'd2:    w_kmod = {1'b0, r_pick[0]};
            3'd3:    w_kmod = mod3(r_pick);
            3'd4:    w_kmod = r_pick[1:0];
            default: w_kmod = 2'd0;
        endcase
        w_k    = {1'b0, w_kmod} + 3'd1;
        w_seen = '0;
        w_eact = '0;
        for (int d = 0; d < ACTION_COUNT; d++) begin
            if (w_open[d]) begin
                w_seen = w_seen + 3'd1;
                if (w_seen == w_k) w_eact = 2'(d);
            end
        end
        if (r_explore)     w_chosen = w_eact;
        else if (w_gfound) w_chosen = w_gact;
        else               w_chosen = w_first;
    end

    assign w_td = clamp_ew(r_target - r_q_old, -LIM62, LIM62);

    always_comb begin
        w_mul_req.start = (r_state == S_MAXQ) || (r_state == S_TD);
        w_mul_req.a     = (r_state == S_MAXQ) ? MW'(w_gm) : MW'(w_td);
        w_mul_req.f     = (r_state == S_MAXQ) ? r_discount : r_learn_rate;
    end

    // memory ports
    always_comb begin
        w_m_we    = 1'b0;
        w_m_addr  = w_nb_addr[r_scan_cnt[1:0]];
        w_m_wdata = CODE_OPEN;
        w_q_we    = 1'b0;
        w_q_addr  = cell_addr(r_cr, r_cc);
        w_q_wdata = r_qrow_old;
        w_q_wdata[r_act*Q_WIDTH +: Q_WIDTH] = r_qn[Q_WIDTH-1:0];
        unique case (r_state)
            S_CLEAR: begin
                w_m_we    = 1'b1;
                w_m_addr  = r_clr;
                w_q_we    = 1'b1;
                w_q_addr  = r_clr;
                w_q_wdata = '0;
            end
            S_START: begin
                w_m_we    = (r_cmd == CMD_LOAD) && w_in_rc;
                w_m_addr  = cell_addr({1'b0, r_row}, {1'b0, r_col});
                w_m_wdata = r_code;
            end
            S_WRITE_OLD: begin
                w_m_we    = 1'b1;
                w_m_addr  = cell_addr(r_agent_row, r_agent_col);
                w_m_wdata = CODE_VISITED;
                w_q_we    = 1'b1;
                w_q_addr  = cell_addr(r_agent_row, r_agent_col);
            end
            S_WRITE_NEW: begin
                w_m_we    = 1'b1;
                w_m_addr  = cell_addr(r_new_row, r_new_col);
                w_m_wdata = CODE_AGENT;
            end
            default: begin
            end
        endcase
    end

    qls_ram #(.W(3), .D(DEPTH)) u_maze_ram (
        .i_clk   (i_clk),
        .i_we    (w_m_we),
        .i_addr  (w_m_addr),
        .i_wdata (w_m_wdata),
        .o_rdata (w_m_rdata)
    );

    qls_ram #(.W(RW), .D(DEPTH)) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_addr  (w_q_addr),
        .i_wdata (w_q_wdata),
        .o_rdata (w_q_rdata)
    );

    qls_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_clr == AW'(DEPTH-1)) n_state = S_IDLE;
            S_IDLE:      if (i_in_valid) n_state = S_START;
            S_START: begin
                unique case (r_cmd)
                    CMD_STEP:  n_state = w_in_agent ? S_SCAN : S_RESULT;
                    CMD_QUERY: n_state = w_in_rc ? S_SCAN : S_RESULT;
                    default:   n_state = S_RESULT;
                endcase
            end
            S_SCAN:      if (r_scan_cnt == 3'd4) n_state = r_phase ? S_MAXQ : S_CHOOSE;
            S_CHOOSE: begin
                if (r_cmd == CMD_STEP && w_cnt != '0) n_state = S_SCAN;
                else n_state = S_RESULT;
            end
            S_MAXQ:      n_state = S_MUL_G;
            S_MUL_G:     if (w_mul_rsp.done) n_state = S_TD;
            S_TD:        n_state = S_MUL_A;
            S_MUL_A:     if (w_mul_rsp.done) n_state = S_WRITE_OLD;
            S_WRITE_OLD: n_state = S_WRITE_NEW;
            S_WRITE_NEW: n_state = S_RESULT;
            S_RESULT:    if (w_adv) n_state = S_IDLE;
            default:     n_state = S_CLEAR;
        endcase
    end

    // configuration, agent position, clearing and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used   <= DEF_ROWS_USED;
            r_cols_used   <= DEF_COLS_USED;
            r_goal_row    <= '0;
            r_goal_col    <= '0;
            r_goal_reward <= DEF_GOAL_REWARD;
            r_learn_rate  <= DEF_LEARN_RATE;
            r_discount    <= DEF_DISCOUNT;
            r_agent_row   <= '0;
            r_agent_col   <= '0;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ROWS_USED:   r_rows_used   <= i_cfg_data[6:0];
                    CFG_COLS_USED:   r_cols_used   <= i_cfg_data[6:0];
                    CFG_GOAL_ROW:    r_goal_row    <= i_cfg_data[5:0];
                    CFG_GOAL_COL:    r_goal_col    <= i_cfg_data[5:0];
                    CFG_GOAL_REWARD: r_goal_reward <= i_cfg_data[9:0];
                    CFG_LEARN_RATE:  r_learn_rate  <= i_cfg_data;
                    CFG_DISCOUNT:    r_discount    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_START && r_cmd == CMD_PLACE && w_in_rc) begin
                r_agent_row <= {1'b0, r_row};
                r_agent_col <= {1'b0, r_col};
            end
            if (r_state == S_WRITE_NEW) begin
                r_agent_row <= r_new_row;
                r_agent_col <= r_new_col;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_row     <= i_row;
            r_col     <= i_col;
            r_code    <= i_cell_code;
            r_explore <= i_explore;
            r_pick    <= i_random_pick;
        end
        unique case (r_state)
            S_START: begin
                r_res_action <= ACT_NONE;
                r_reward     <= '0;
                r_qn         <= '0;
                r_phase      <= 1'b0;
                r_scan_cnt   <= '0;
                if (r_cmd == CMD_STEP) begin
                    r_cr <= r_agent_row;
                    r_cc <= r_agent_col;
                    r_res_status <= w_in_agent ? STAT_OK : STAT_RANGE;
                end else begin
                    r_cr <= {1'b0, r_row};
                    r_cc <= {1'b0, r_col};
                    r_res_status <= w_in_rc ? STAT_OK : STAT_RANGE;
                end
            end
            S_SCAN: begin
                r_scan_cnt <= r_scan_cnt + 3'd1;
                if (r_scan_cnt != '0) r_nb_code[r_scan_cnt[1:0] - 2'd1] <= w_m_rdata;
                if (r_scan_cnt == 3'd1) r_qrow <= w_q_rdata;
            end
            S_CHOOSE: begin
                if (r_cmd == CMD_QUERY) begin
                    if (w_qfound) begin
                        r_res_action <= {1'b0, w_qact};
                        r_qn         <= w_qm;
                    end else begin
                        r_res_status <= STAT_NO_OPEN;
                    end
                end else if (w_cnt == '0) begin
                    r_res_status <= STAT_NO_OPEN;
                end else begin
                    r_act        <= w_chosen;
                    r_res_action <= {1'b0, w_chosen};
                    r_q_old      <= w_qv[w_chosen];
                    r_qrow_old   <= r_qrow;
                    r_new_row    <= w_nb_row[w_chosen];
                    r_new_col    <= w_nb_col[w_chosen];
                    r_cr         <= w_nb_row[w_chosen];
                    r_cc         <= w_nb_col[w_chosen];
                    r_phase      <= 1'b1;
                    r_scan_cnt   <= '0;
                    if (r_nb_code[w_chosen] == CODE_VISITED) begin
                        r_reward <= REWARD_VISITED;
                    end else if (w_nb_row[w_chosen] == {1'b0, r_goal_row}
                                 && w_nb_col[w_chosen] == {1'b0, r_goal_col}) begin
                        r_reward <= signed'({1'b0, r_goal_reward});
                    end else begin
                        r_reward <= REWARD_STEP;
                    end
                end
            end
            S_MUL_G: begin
                if (w_mul_rsp.done) begin
                    r_target <= clamp_ew((EW'(r_reward) <<< FW) + EW'($signed(w_mul_rsp.res)),
                                         -LIM62, LIM62);
                end
            end
            S_MUL_A: begin
                if (w_mul_rsp.done) begin
                    r_qn <= clamp_ew(r_q_old + EW'($signed(w_mul_rsp.res)), QMIN, QMAX);
                end
            end
            default: begin
            end
        endcase
        if (w_adv) begin
            r_o_action    <= r_res_action;
            r_o_reward    <= r_reward;
            r_o_agent_row <= r_agent_row[5:0];
            r_o_agent_col <= r_agent_col[5:0];
            r_o_q_new     <= r_qn[31:0];
            r_o_status    <= r_res_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_action        = r_o_action;
    assign o_reward        = r_o_reward;
    assign o_agent_row_out = r_o_agent_row;
    assign o_agent_col_out = r_o_agent_col;
    assign o_q_new         = r_o_q_new;
    assign o_status        = r_o_status;

endmodule

// ----- hw/rtl/qls_checker.sv -----
// ----------------------------------------------------------------------------
// qls_checker
// port-level checks of the grid q-learning step block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_q_learning_step_macros.svh"

module qls_port_checker import qls_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         o_action,
    input logic signed [10:0] o_reward,
    input logic [1:0]         o_status
);

    `QLS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `QLS_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `QLS_ASSERT_IMP(a_act_ok, i_clk, i_rst_n, o_out_valid && o_action != ACT_NONE, o_status == STAT_OK)
    `QLS_ASSERT_IMP(a_fail_quiet, i_clk, i_rst_n, o_out_valid && o_status != STAT_OK, o_action == ACT_NONE && o_reward == '0)

endmodule

bind grid_q_learning_step qls_port_checker u_qls_port_checker (.*);
